@@ rtl/core/lcdcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdcc_pkg
// Shared types and constants of the character LCD command capture core.
// ----------------------------------------------------------------------------
package lcdcc_pkg;

	localparam int LINES   = 2;
	localparam int COLUMNS = 16;
	localparam int CELLS   = LINES * COLUMNS;

	localparam int IDX_W = 5;
	localparam int COL_W = 5;

	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_LINE2  = 8'hC0;
	localparam logic [7:0] BLANK_CHAR = 8'h20;

	typedef struct packed {
		logic             reg_select;
		logic             strobe_req;
		logic [7:0]       bus_byte;
		logic [IDX_W-1:0] refresh_index;
	} cmd_item_t;

	typedef struct packed {
		logic             char_written;
		logic [IDX_W-1:0] written_index;
		logic             display_cleared;
		logic             row_now;
		logic [COL_W-1:0] column_now;
		logic [7:0]       refresh_char;
		logic             refresh_filled;
	} rsp_item_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [7:0]       wr_data;
		logic             clear;
	} cell_wr_t;

endpackage

@@ rtl/core/lcdcc_cursor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdcc_cursor
// Strobe edge detection, command decode and cursor tracking.
// ----------------------------------------------------------------------------
module lcdcc_cursor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  lcdcc_pkg::cmd_item_t         item,
	output lcdcc_pkg::cell_wr_t          wr,
	output logic                         row_now,
	output logic [lcdcc_pkg::COL_W-1:0]  column_now
);

	logic                        last_strobe_q;
	logic                        row_q;
	logic [lcdcc_pkg::COL_W-1:0] col_q;
	logic                        rise;
	logic                        row_d;
	logic [lcdcc_pkg::COL_W-1:0] col_d;
	lcdcc_pkg::cell_wr_t         wr_d;

	assign rise = item.strobe_req & ~last_strobe_q;

	always_comb begin
		row_d = row_q;
		col_d = col_q;
		wr_d  = '0;
		if (rise) begin
			if (!item.reg_select) begin
				unique case (item.bus_byte)
					lcdcc_pkg::CMD_CLEAR: begin
						row_d      = 1'b0;
						col_d      = '0;
						wr_d.clear = 1'b1;
					end
					lcdcc_pkg::CMD_LINE2: begin
						row_d = (lcdcc_pkg::LINES >= 2);
						col_d = '0;
					end
					default: begin
					end
				endcase
			end else if ((int'(row_q) < lcdcc_pkg::LINES) &&
				(int'(col_q) < lcdcc_pkg::COLUMNS)) begin
				wr_d.wr_en   = 1'b1;
				wr_d.wr_idx  = lcdcc_pkg::IDX_W'(int'(row_q) * lcdcc_pkg::COLUMNS
					+ int'(col_q));
				wr_d.wr_data = item.bus_byte;
				col_d        = col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_strobe_q <= 1'b0;
			row_q         <= 1'b0;
			col_q         <= '0;
		end else if (step) begin
			last_strobe_q <= item.strobe_req;
			row_q         <= row_d;
			col_q         <= col_d;
		end
	end

	assign wr         = wr_d;
	assign row_now    = row_d;
	assign column_now = col_d;

endmodule

@@ rtl/core/lcdcc_cells.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdcc_cells
// Display cell store with filled flags and same-cycle refresh readback.
// ----------------------------------------------------------------------------
module lcdcc_cells (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  lcdcc_pkg::cell_wr_t          wr,
	input  logic [lcdcc_pkg::IDX_W-1:0]  refresh_index,
	output logic [7:0]                   refresh_char,
	output logic                         refresh_filled
);

	logic [7:0] chars_q  [lcdcc_pkg::CELLS];
	logic       filled_q [lcdcc_pkg::CELLS];
	logic       fill_rd;
	logic [7:0] char_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lcdcc_pkg::CELLS; i++) begin
				filled_q[i] <= 1'b0;
			end
		end else if (step) begin
			if (wr.clear) begin
				for (int i = 0; i < lcdcc_pkg::CELLS; i++) begin
					filled_q[i] <= 1'b0;
				end
			end else if (wr.wr_en) begin
				filled_q[wr.wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr.wr_en) begin
			chars_q[wr.wr_idx] <= wr.wr_data;
		end
	end

	// readback reflects this item's write or clear
	always_comb begin
		fill_rd = 1'b0;
		char_rd = lcdcc_pkg::BLANK_CHAR;
		if (int'(refresh_index) < lcdcc_pkg::CELLS) begin
			if (wr.clear) begin
				fill_rd = 1'b0;
			end else if (wr.wr_en && (wr.wr_idx == refresh_index)) begin
				fill_rd = 1'b1;
				char_rd = wr.wr_data;
			end else begin
				fill_rd = filled_q[refresh_index];
				char_rd = chars_q[refresh_index];
			end
		end
		refresh_filled = fill_rd;
		refresh_char   = fill_rd ? char_rd : lcdcc_pkg::BLANK_CHAR;
	end

endmodule

@@ rtl/core/char_lcd_command_capture_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_command_capture_core
// Captures character LCD pin samples, tracks cursor and display cells.
//
//   channel  direction  handshake            payload
//   cmd      in         cmd_valid/cmd_stall  cmd_item_t pin sample
//   rsp      out        rsp_valid/rsp_stall  rsp_item_t write, cursor, refresh
//
// one item per cycle sustained while rsp_stall does not hold the result register
// input register feeds decode and cell update, result register drives rsp
// arst_n clears cursor, strobe history, filled flags and valid bits
// rsp_stall holds the result register and back-pressures cmd through stage one
// ----------------------------------------------------------------------------
module char_lcd_command_capture_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  lcdcc_pkg::cmd_item_t cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output lcdcc_pkg::rsp_item_t rsp
);

	logic                 valid_s1;
	lcdcc_pkg::cmd_item_t item_s1;
	logic                 rsp_valid_q;
	lcdcc_pkg::rsp_item_t rsp_q;
	logic                 adv;
	logic                 step;
	lcdcc_pkg::cell_wr_t  wr;
	lcdcc_pkg::rsp_item_t res;

	assign adv       = ~rsp_valid_q | ~rsp_stall;
	assign step      = valid_s1 & adv;
	assign cmd_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	lcdcc_cursor u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.wr         (wr),
		.row_now    (res.row_now),
		.column_now (res.column_now)
	);

	lcdcc_cells u_cells (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.wr             (wr),
		.refresh_index  (item_s1.refresh_index),
		.refresh_char   (res.refresh_char),
		.refresh_filled (res.refresh_filled)
	);

	assign res.char_written    = wr.wr_en;
	assign res.written_index   = wr.wr_en ? wr.wr_idx : '0;
	assign res.display_cleared = wr.clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
